// ===== src/spdt_pkg.sv =====
//------------------------------------------------------------------------------
// Sorted priority deadline table package
// Shared request/result types and codes.
//------------------------------------------------------------------------------
package spdt_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_REMOVE  = 2'd1,
        ACT_EXTRACT = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] task_id;
        logic [7:0]  priority_req;
        logic [31:0] deadline;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_id;
        logic [7:0]  found_priority;
        logic [31:0] found_deadline;
        logic [4:0]  entry_count;
    } result_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [31:0] dl;
    } entry_t;

    // True when entry a must be placed strictly ahead of entry b.
    function automatic logic goes_before(input logic [7:0] pa, input logic [31:0] da,
                                         input logic [7:0] pb, input logic [31:0] db);
        logic r;
        if (pa != pb)
            r = (pa > pb);
        else if (da == 32'd0)
            r = 1'b0;
        else if (db == 32'd0)
            r = 1'b1;
        else
            r = (da < db);
        return r;
    endfunction

endpackage

// ===== src/spdt_mem.sv =====
//------------------------------------------------------------------------------
// Sorted priority deadline table entry memory
// One write port and one registered read port.
//------------------------------------------------------------------------------
module spdt_mem #(
    parameter int AW = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  spdt_pkg::entry_t wdata,
    input  logic [AW-1:0]    raddr,
    output spdt_pkg::entry_t rdata
);
    import spdt_pkg::*;

    entry_t mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== src/sorted_priority_deadline_table_core.sv =====
//------------------------------------------------------------------------------
// Sorted priority deadline table core
// Each request walks the table held in a single-port-read memory: one entry is
// read per cycle, and the entry is written back into its new slot (shifted up
// for an insert, compacted down for a remove or extract). After a request is
// accepted, busy stays high while the walk reads every held entry and then
// through the end state. An insert into a full table, action code 3,
// and any request on an empty table skip the walk and keep busy high for one
// cycle. The result appears on result with done high in the cycle after busy
// falls. The receiver cannot stall the result. Requests with start while busy
// are ignored.
//------------------------------------------------------------------------------
module sorted_priority_deadline_table_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  spdt_pkg::request_t request,
    output logic               busy,
    output logic               done,
    output spdt_pkg::result_t  result
);
    import spdt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_END  = 3'b100
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  rd_reg, rd_next;     // next index read
    logic [CW-1:0]  wr_reg, wr_next;     // next write slot
    logic           placed_reg, placed_next;
    logic           hit_reg, hit_next;
    logic           pend_reg, pend_next; // read data valid this cycle
    request_t       req_reg, req_next;
    entry_t         hold_reg, hold_next; // entry waiting to go one slot up
    entry_t         found_reg, found_next;
    logic [1:0]     stat_reg, stat_next;
    logic           done_reg, done_next;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    entry_t         wdata, rdata, new_e;

    spdt_mem #(.AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign new_e = '{id: req_reg.task_id, prio: req_reg.priority_req,
                     dl: req_reg.deadline};
    // While idle the first entry is read so that it is ready when the walk starts.
    assign raddr = (state_reg == S_IDLE) ? '0 : rd_reg[AW-1:0];
    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    always_comb
    begin
        result.status         = stat_reg;
        result.found_id       = found_reg.id;
        result.found_priority = found_reg.prio;
        result.found_deadline = found_reg.dl;
        result.entry_count    = 5'(count_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_next     = rd_reg;
        wr_next     = wr_reg;
        placed_next = placed_reg;
        hit_next    = hit_reg;
        pend_next   = 1'b0;
        req_next    = req_reg;
        hold_next   = hold_reg;
        found_next  = found_reg;
        stat_next   = stat_reg;
        done_next   = 1'b0;
        we          = 1'b0;
        waddr       = wr_reg[AW-1:0];
        wdata       = rdata;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = request;
                    rd_next     = '0;
                    wr_next     = '0;
                    placed_next = 1'b0;
                    hit_next    = 1'b0;
                    found_next  = '0;
                    stat_next   = ST_DONE;
                    if (request.action == ACT_INSERT && count_reg == CW'(TABLE_DEPTH))
                    begin
                        stat_next  = ST_FULL;
                        state_next = S_END;
                    end
                    else if (request.action == ACT_NONE || count_reg == '0)
                        state_next = S_END;
                    else
                    begin
                        state_next = S_WALK;
                        rd_next    = CW'(1);
                        pend_next  = 1'b1;
                    end
                end
            end
            S_WALK:
            begin
                // rdata holds entry rd_reg-1
                if (pend_reg)
                begin
                    case (req_reg.action)
                        ACT_INSERT:
                        begin
                            if (placed_reg)
                            begin
                                we        = 1'b1;
                                wdata     = hold_reg;
                                hold_next = rdata;
                            end
                            else if (goes_before(new_e.prio, new_e.dl,
                                                 rdata.prio, rdata.dl))
                            begin
                                we          = 1'b1;
                                wdata       = new_e;
                                hold_next   = rdata;
                                placed_next = 1'b1;
                            end
                            wr_next = wr_reg + CW'(1);
                        end
                        ACT_REMOVE:
                        begin
                            if (rdata.id != req_reg.task_id)
                            begin
                                we      = 1'b1;
                                wr_next = wr_reg + CW'(1);
                            end
                        end
                        default:
                        begin
                            if (!hit_reg && rdata.id == req_reg.task_id)
                            begin
                                hit_next   = 1'b1;
                                found_next = rdata;
                            end
                            else
                            begin
                                we      = 1'b1;
                                wr_next = wr_reg + CW'(1);
                            end
                        end
                    endcase
                end
                if (rd_reg < count_reg)
                begin
                    rd_next   = rd_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                    state_next = S_END;
            end
            S_END:
            begin
                // Final write for insert and count update; a missed extract reports not found.
                case (req_reg.action)
                    ACT_INSERT:
                    begin
                        if (stat_reg == ST_DONE)
                        begin
                            we         = 1'b1;
                            wdata      = placed_reg ? hold_reg : new_e;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    ACT_REMOVE:
                        count_next = wr_reg;
                    ACT_EXTRACT:
                    begin
                        if (hit_reg)
                            count_next = count_reg - CW'(1);
                        else
                            stat_next = ST_NOT_FOUND;
                    end
                    default: ;
                endcase
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg     <= rd_next;
        wr_reg     <= wr_next;
        placed_reg <= placed_next;
        hit_reg    <= hit_next;
        req_reg    <= req_next;
        hold_reg   <= hold_next;
        found_reg  <= found_next;
        stat_reg   <= stat_next;
    end

endmodule

// ===== src/spdt_checker.sv =====
//------------------------------------------------------------------------------
// Sorted priority deadline table checker
// Port-level properties of the core, bound to every instance of the core.
//------------------------------------------------------------------------------
module spdt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input spdt_pkg::result_t  result
);
    import spdt_pkg::*;

    // An accepted request makes the core busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accepted request not busy");

    // A result closes the request: the core is idle while done is high.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");

    // Results never come back to back.
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("back to back results");

    // The found id is zero on any result whose status is not done.
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_DONE |-> result.found_id == '0)
        else $error("found id on failure");

endmodule

bind sorted_priority_deadline_table_core spdt_checker u_spdt_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .result(result)
);

// ===== tb/sorted_priority_deadline_table_core_tb.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Sorted priority deadline table core testbench
// Drives insert, remove, extract and no-op requests from a queue. The sender idles in
// random bursts. A table model inside the testbench predicts every result, and
// each result marked by done is checked field by field against the oldest
// prediction.
//------------------------------------------------------------------------------
module sorted_priority_deadline_table_core_tb;
    import spdt_pkg::*;

    localparam int DEPTH = 16;

    logic     clk;
    logic     rst_n;
    logic     start;
    request_t request;
    logic     busy;
    logic     done;
    result_t  result;

    sorted_priority_deadline_table_core #(.TABLE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .request(request),
        .busy(busy), .done(done), .result(result)
    );

    request_t    pending_requests[$];
    result_t     predicted_results[$];
    entry_t      table_rows[DEPTH];
    int unsigned row_count;
    int          fail_count;
    bit          calm;
    bit          stimulus_done;
    int          gap_left;
    int unsigned id_pool[4];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("sorted_priority_deadline_table_core verification failed");
        $finish;
    end

    task automatic queue_request(request_t r);
        pending_requests = {pending_requests, r};
    endtask

    task automatic record_prediction(result_t r);
        predicted_results = {predicted_results, r};
    endtask

    function automatic logic entry_ahead(logic [7:0] pa, logic [31:0] da,
                                         logic [7:0] pb, logic [31:0] db);
        if (pa != pb)
            return pa > pb;
        if (da == 32'd0)
            return 1'b0;
        if (db == 32'd0)
            return 1'b1;
        return da < db;
    endfunction

    // Applies one request to the table copy and returns its result.
    function automatic result_t apply_table_request(request_t req);
        result_t     res;
        int unsigned pos;
        int unsigned w;
        res = '0;
        res.status = ST_DONE;
        case (action_t'(req.action))
            ACT_INSERT:
            begin
                if (row_count >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    pos = row_count;
                    for (int i = 0; i < row_count; i++)
                        if (entry_ahead(req.priority_req, req.deadline,
                                        table_rows[i].prio, table_rows[i].dl))
                        begin
                            pos = i;
                            break;
                        end
                    for (int i = row_count; i > pos; i--)
                        table_rows[i] = table_rows[i-1];
                    table_rows[pos] = '{req.task_id, req.priority_req, req.deadline};
                    row_count++;
                end
            end
            ACT_REMOVE:
            begin
                w = 0;
                for (int i = 0; i < row_count; i++)
                    if (table_rows[i].id != req.task_id)
                    begin
                        table_rows[w] = table_rows[i];
                        w++;
                    end
                row_count = w;
            end
            ACT_EXTRACT:
            begin
                res.status = ST_NOT_FOUND;
                for (int i = 0; i < row_count; i++)
                    if (table_rows[i].id == req.task_id)
                    begin
                        res.found_id       = table_rows[i].id;
                        res.found_priority = table_rows[i].prio;
                        res.found_deadline = table_rows[i].dl;
                        res.status         = ST_DONE;
                        for (int j = i; j + 1 < row_count; j++)
                            table_rows[j] = table_rows[j+1];
                        row_count--;
                        break;
                    end
            end
            default: ;
        endcase
        res.entry_count = row_count[4:0];
        return res;
    endfunction

    function automatic request_t make_request(logic [1:0] act, logic [15:0] id,
                                              logic [7:0] pr, logic [31:0] dl);
        request_t r;
        r.action = act;
        r.task_id = id;
        r.priority_req = pr;
        r.deadline = dl;
        return r;
    endfunction

    function automatic logic [15:0] pick_id();
        if ($urandom_range(0, 9) < 8)
            return 16'(id_pool[$urandom_range(0, 3)]);
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_prio();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'hFF;
            2: return 8'($urandom_range(0, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_deadline();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(1, 4));
            default: return 32'($urandom);
        endcase
    endfunction

    initial
    begin
        int unsigned roll;
        logic [1:0]  act;
        for (int i = 0; i < 4; i++)
            id_pool[i] = $urandom;
        id_pool[0] = 16'hFFFF;
        // Directed part: extract and remove on empty, no-op, fill past full, ties, extract, remove.
        queue_request(make_request(ACT_EXTRACT, 16'h0000, 8'h00, 32'h0));
        queue_request(make_request(ACT_REMOVE, 16'h1234, 8'h00, 32'h0));
        queue_request(make_request(ACT_NONE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
        for (int i = 0; i < 17; i++)
            queue_request(make_request(ACT_INSERT, i[15:0] % 3,
                8'(i % 2 ? 8'hFF : 8'h00), (i % 4 == 0) ? 32'h0 :
                (i % 4 == 1 ? 32'hFFFF_FFFF : 32'(i))));
        queue_request(make_request(ACT_EXTRACT, 16'h0001, 8'h00, 32'h0));
        queue_request(make_request(ACT_REMOVE, 16'h0000, 8'h00, 32'h0));
        queue_request(make_request(ACT_EXTRACT, 16'h0007, 8'h00, 32'h0));
        queue_request(make_request(ACT_REMOVE, 16'h0002, 8'h00, 32'h0));
        for (int n = 0; n < 1600; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                act = ACT_INSERT;
            else if (roll < 68)
                act = ACT_EXTRACT;
            else if (roll < 83)
                act = ACT_REMOVE;
            else if (roll < 88)
                act = ACT_NONE;
            else
                act = 2'($urandom);
            queue_request(make_request(act, pick_id(), pick_prio(),
                                       pick_deadline()));
        end
    end

    // Driver: start is held while busy and lowered only during an idle burst or once the queue is empty.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            request  <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                record_prediction(apply_table_request(request));
            if (start && busy)
                ;
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_requests.size() > 0 && !calm && $urandom_range(0, 7) == 0)
            begin
                start    <= 1'b0;
                gap_left <= $urandom_range(1, 18) - 1;
            end
            else if (pending_requests.size() > 0)
            begin
                start   <= 1'b1;
                request <= pending_requests.pop_front();
                calm    <= pending_requests.size() < 300;
            end
            else
            begin
                start         <= 1'b0;
                stimulus_done <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                fail_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                if (result.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, result.status);
                if (result.found_id !== want.found_id)
                    $display("%0t: found_id expected %h actual %h", $time,
                             want.found_id, result.found_id);
                if (result.found_priority !== want.found_priority)
                    $display("%0t: found_priority expected %h actual %h", $time,
                             want.found_priority, result.found_priority);
                if (result.found_deadline !== want.found_deadline)
                    $display("%0t: found_deadline expected %h actual %h", $time,
                             want.found_deadline, result.found_deadline);
                if (result.entry_count !== want.entry_count)
                    $display("%0t: entry_count expected %0d actual %0d", $time,
                             want.entry_count, result.entry_count);
                if (result !== want)
                    fail_count++;
            end
        end
    end

    initial
    begin
        fail_count    = 0;
        row_count     = 0;
        calm          = 1'b0;
        stimulus_done = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        request       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (stimulus_done && predicted_results.size() == 0);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && predicted_results.size() == 0)
            $display("sorted_priority_deadline_table_core verification clean");
        else
            $display("sorted_priority_deadline_table_core verification failed");
        $finish;
    end

endmodule
